>>> sv/sldm_pkg.sv
// Shared types, codes and a helper function for the sorted list difference merge.
package sldm_pkg;

	localparam int KEY_FIELD_BITS = 64;
	localparam int SEQ_BITS = 64;
	localparam int KEY_BITS_DEFAULT = 64;

	typedef enum logic [2:0] {
		CMD_DEST_ENTRY = 3'd0,
		CMD_SRC_ENTRY  = 3'd1,
		CMD_DEST_END   = 3'd2,
		CMD_SRC_END    = 3'd3,
		CMD_ABORT      = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_UPDATE  = 3'd1,
		ACT_DELETE  = 3'd2,
		ACT_DONE    = 3'd3,
		ACT_ABORTED = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		SIDE_DEST = 2'd0,
		SIDE_SRC  = 2'd1,
		SIDE_NONE = 2'd2
	} side_t;

	typedef struct packed {
		logic dest_valid;
		logic src_valid;
		logic dest_ended;
		logic src_ended;
		logic stopped;
	} flags_t;

	typedef struct packed {
		action_t action;
		logic    dest_was_newer;
		side_t   need_side;
		logic    wrong_side;
	} result_t;

	typedef struct packed {
		logic load_dest;
		logic load_src;
	} load_t;

	function automatic side_t side_wanted(input flags_t f);
		side_t s;
		if (f.stopped) begin
			s = SIDE_NONE;
		end else if (!f.dest_valid && !f.dest_ended) begin
			s = SIDE_DEST;
		end else if (!f.src_valid && !f.src_ended) begin
			s = SIDE_SRC;
		end else begin
			s = SIDE_NONE;
		end
		return s;
	endfunction

endpackage

>>> sv/sldm_req_if.sv
// Request channel carrying one command with its entry key and sequence id.
interface sldm_req_if
	import sldm_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [2:0]                command;
	logic [KEY_FIELD_BITS-1:0] entry_key;
	logic signed [SEQ_BITS-1:0] entry_seq;

	modport source (output valid, output command, output entry_key, output entry_seq,
		input ready);
	modport sink (input valid, input command, input entry_key, input entry_seq,
		output ready);
endinterface

>>> sv/sldm_rsp_if.sv
// Result channel carrying the merge action and the side wanted next.
interface sldm_rsp_if
	import sldm_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [2:0]                action;
	logic [KEY_FIELD_BITS-1:0] out_key;
	logic                      dest_was_newer;
	logic [1:0]                need_side;
	logic                      wrong_side;

	modport source (output valid, output action, output out_key, output dest_was_newer,
		output need_side, output wrong_side, input ready);
	modport sink (input valid, input action, input out_key, input dest_was_newer,
		input need_side, input wrong_side, output ready);
endinterface

>>> sv/sldm_step.sv
// Combinational merge decision for one request against the held heads.
module sldm_step
	import sldm_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
	input  logic [2:0]                 cmd,
	input  logic [KEY_BITS-1:0]        key,
	input  logic signed [SEQ_BITS-1:0] seq,
	input  flags_t                     flags,
	input  logic [KEY_BITS-1:0]        dest_key,
	input  logic signed [SEQ_BITS-1:0] dest_seq,
	input  logic [KEY_BITS-1:0]        src_key,
	input  logic signed [SEQ_BITS-1:0] src_seq,
	output flags_t                     flags_nxt,
	output load_t                      load,
	output result_t                    res,
	output logic [KEY_BITS-1:0]        res_key
);

	logic [KEY_BITS-1:0]        dk;
	logic [KEY_BITS-1:0]        sk;
	logic signed [SEQ_BITS-1:0] ds;
	logic signed [SEQ_BITS-1:0] ss;
	side_t                      need_cur;
	logic                       is_dest_cmd;
	logic                       is_src_cmd;

	// Heads as they stand once this request's entry is taken in.
	assign dk = (cmd == CMD_DEST_ENTRY) ? key : dest_key;
	assign ds = (cmd == CMD_DEST_ENTRY) ? seq : dest_seq;
	assign sk = (cmd == CMD_SRC_ENTRY) ? key : src_key;
	assign ss = (cmd == CMD_SRC_ENTRY) ? seq : src_seq;

	assign need_cur = side_wanted(flags);
	assign is_dest_cmd = (cmd == CMD_DEST_ENTRY) || (cmd == CMD_DEST_END);
	assign is_src_cmd = (cmd == CMD_SRC_ENTRY) || (cmd == CMD_SRC_END);

	always_comb begin
		flags_nxt = flags;
		load = '0;
		res.action = ACT_NONE;
		res.dest_was_newer = 1'b0;
		res.wrong_side = 1'b0;
		res_key = '0;

		priority if (cmd == CMD_ABORT) begin
			if (!flags.stopped) begin
				flags_nxt.stopped = 1'b1;
				res.action = ACT_ABORTED;
			end
		end else if (cmd > CMD_ABORT || flags.stopped) begin
			res.wrong_side = 1'b1;
		end else if (is_dest_cmd && need_cur != SIDE_DEST) begin
			res.wrong_side = 1'b1;
		end else if (is_src_cmd && need_cur != SIDE_SRC) begin
			res.wrong_side = 1'b1;
		end else begin
			unique case (cmd)
				CMD_DEST_ENTRY: begin
					load.load_dest = 1'b1;
					flags_nxt.dest_valid = 1'b1;
				end
				CMD_SRC_ENTRY: begin
					load.load_src = 1'b1;
					flags_nxt.src_valid = 1'b1;
				end
				CMD_DEST_END: begin
					flags_nxt.dest_ended = 1'b1;
				end
				CMD_SRC_END: begin
					flags_nxt.src_ended = 1'b1;
				end
				default: begin
				end
			endcase

			priority if (flags_nxt.dest_valid && flags_nxt.src_valid) begin
				priority if (dk == sk) begin
					if (ds != ss) begin
						res.action = ACT_UPDATE;
						res_key = sk;
						res.dest_was_newer = (ds > ss);
					end
					flags_nxt.dest_valid = 1'b0;
					flags_nxt.src_valid = 1'b0;
				end else if (dk > sk) begin
					res.action = ACT_UPDATE;
					res_key = sk;
					flags_nxt.src_valid = 1'b0;
				end else begin
					res.action = ACT_DELETE;
					res_key = dk;
					flags_nxt.dest_valid = 1'b0;
				end
			end else if (flags_nxt.dest_valid && flags_nxt.src_ended) begin
				res.action = ACT_DELETE;
				res_key = dk;
				flags_nxt.dest_valid = 1'b0;
			end else if (flags_nxt.src_valid && flags_nxt.dest_ended) begin
				res.action = ACT_UPDATE;
				res_key = sk;
				flags_nxt.src_valid = 1'b0;
			end else if (flags_nxt.dest_ended && flags_nxt.src_ended
					&& !flags_nxt.dest_valid && !flags_nxt.src_valid) begin
				res.action = ACT_DONE;
				flags_nxt.stopped = 1'b1;
			end else begin
			end
		end

		res.need_side = side_wanted(flags_nxt);
	end

endmodule

>>> sv/sorted_list_diff_merge.sv
// An accepted request passes the request register and then the result register.
// Throughput: one request per cycle unless the result channel stalls; the single
// key compare of the step logic sets it. Each request yields exactly one result,
// and a full result register does not block a new request while the request
// register can still move forward. Reset clears all head valid bits, end marks and
// the stopped flag; a new merge starts only after reset.
module sorted_list_diff_merge
	import sldm_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	sldm_req_if.sink   req,
	sldm_rsp_if.source rsp
);

	// Request register: the accepted command and entry wait here until advance is high.
	logic                       valid_s1;
	logic [2:0]                 cmd_s1;
	logic [KEY_BITS-1:0]        key_s1;
	logic signed [SEQ_BITS-1:0] seq_s1;

	// Merge state: one head entry per side plus the progress flags.
	flags_t                     flags_q;
	logic [KEY_BITS-1:0]        dest_key_q;
	logic signed [SEQ_BITS-1:0] dest_seq_q;
	logic [KEY_BITS-1:0]        src_key_q;
	logic signed [SEQ_BITS-1:0] src_seq_q;

	// Result register.
	logic                       valid_s2;
	result_t                    res_s2;
	logic [KEY_BITS-1:0]        key_s2;

	flags_t                     flags_nxt;
	load_t                      load;
	result_t                    res;
	logic [KEY_BITS-1:0]        res_key;
	logic                       advance;

	// The request register moves on whenever the result register is free or is
	// being emptied in this same cycle, so back-to-back requests flow without gaps.
	assign advance = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= req.command;
			key_s1 <= req.entry_key[KEY_BITS-1:0];
			seq_s1 <= req.entry_seq;
		end
	end

	sldm_step #(
		.KEY_BITS(KEY_BITS)
	) u_step (
		.cmd      (cmd_s1),
		.key      (key_s1),
		.seq      (seq_s1),
		.flags    (flags_q),
		.dest_key (dest_key_q),
		.dest_seq (dest_seq_q),
		.src_key  (src_key_q),
		.src_seq  (src_seq_q),
		.flags_nxt(flags_nxt),
		.load     (load),
		.res      (res),
		.res_key  (res_key)
	);

	// The state is committed in the cycle the request leaves the request register,
	// which is also the cycle its result is captured, so the next request always
	// sees the state this one leaves behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				flags_q <= flags_nxt;
			end
		end
	end

	// Head entries are payload only; their valid bits in the flags guard every use.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
			key_s2 <= res_key;
			if (load.load_dest) begin
				dest_key_q <= key_s1;
				dest_seq_q <= seq_s1;
			end
			if (load.load_src) begin
				src_key_q <= key_s1;
				src_seq_q <= seq_s1;
			end
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.action = res_s2.action;
	assign rsp.out_key = KEY_FIELD_BITS'(key_s2);
	assign rsp.dest_was_newer = res_s2.dest_was_newer;
	assign rsp.need_side = res_s2.need_side;
	assign rsp.wrong_side = res_s2.wrong_side;

endmodule

>>> verif/sldm_merge_checker.sv
// Checker for the sorted list difference merge: predicts every result and compares it.
module sldm_merge_checker
	import sldm_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	sldm_req_if        req,
	sldm_rsp_if        rsp,
	output int         fail_count,
	output int         pending,
	output side_t      want_side
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KEY_FIELD_BITS-1:0] KEY_MASK =
		{KEY_FIELD_BITS{1'b1}} >> (KEY_FIELD_BITS - KEY_BITS);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		action_t                   action;
		logic [KEY_FIELD_BITS-1:0] key;
		logic                      newer;
		side_t                     need;
		logic                      wrong;
	} merge_step_t;

	logic [KEY_FIELD_BITS-1:0] dest_key, src_key;
	logic signed [SEQ_BITS-1:0] dest_seq, src_seq;
	logic dest_held, src_held, dest_closed, src_closed, halted;
	merge_step_t expected_steps[$];

	function automatic side_t side_now();
		if (halted) begin
			return SIDE_NONE;
		end else if (!dest_held && !dest_closed) begin
			return SIDE_DEST;
		end else if (!src_held && !src_closed) begin
			return SIDE_SRC;
		end
		return SIDE_NONE;
	endfunction

	// One accepted request: update the merge state and work out its result.
	task automatic merge_step(input logic [2:0] cmd, input logic [KEY_FIELD_BITS-1:0] key_in,
		input logic signed [SEQ_BITS-1:0] seq_in, output merge_step_t res);
		side_t need;
		logic [KEY_FIELD_BITS-1:0] key;
		need = side_now();
		key = key_in & KEY_MASK;
		res = '0;
		res.action = ACT_NONE;
		if (cmd == CMD_ABORT) begin
			if (!halted) begin
				halted = 1'b1;
				res.action = ACT_ABORTED;
			end
		end else if (cmd > CMD_ABORT || halted) begin
			res.wrong = 1'b1;
		end else if ((cmd == CMD_DEST_ENTRY || cmd == CMD_DEST_END) && need != SIDE_DEST) begin
			res.wrong = 1'b1;
		end else if ((cmd == CMD_SRC_ENTRY || cmd == CMD_SRC_END) && need != SIDE_SRC) begin
			res.wrong = 1'b1;
		end else begin
			case (cmd)
				CMD_DEST_ENTRY: begin
					dest_key = key;
					dest_seq = seq_in;
					dest_held = 1'b1;
				end
				CMD_SRC_ENTRY: begin
					src_key = key;
					src_seq = seq_in;
					src_held = 1'b1;
				end
				CMD_DEST_END: dest_closed = 1'b1;
				default: src_closed = 1'b1;
			endcase
			if (dest_held && src_held) begin
				if (dest_key == src_key) begin
					if (dest_seq != src_seq) begin
						res.action = ACT_UPDATE;
						res.key = src_key;
						res.newer = dest_seq > src_seq;
					end
					dest_held = 1'b0;
					src_held = 1'b0;
				end else if (dest_key > src_key) begin
					res.action = ACT_UPDATE;
					res.key = src_key;
					src_held = 1'b0;
				end else begin
					res.action = ACT_DELETE;
					res.key = dest_key;
					dest_held = 1'b0;
				end
			end else if (dest_held && src_closed) begin
				res.action = ACT_DELETE;
				res.key = dest_key;
				dest_held = 1'b0;
			end else if (src_held && dest_closed) begin
				res.action = ACT_UPDATE;
				res.key = src_key;
				src_held = 1'b0;
			end else if (dest_closed && src_closed && !dest_held && !src_held) begin
				res.action = ACT_DONE;
				halted = 1'b1;
			end
		end
		res.need = side_now();
	endtask

	always @(posedge clk or negedge arst_n) begin
		merge_step_t exp;
		if (!arst_n) begin
			dest_key = '0;
			dest_seq = '0;
			dest_held = 1'b0;
			src_key = '0;
			src_seq = '0;
			src_held = 1'b0;
			dest_closed = 1'b0;
			src_closed = 1'b0;
			halted = 1'b0;
			expected_steps.delete();
			pending <= 0;
			want_side <= SIDE_DEST;
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				merge_step(req.command, req.entry_key, req.entry_seq, exp);
				expected_steps.insert(expected_steps.size(), exp);
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (expected_steps.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("unexpected result: action=%0d key=%h", rsp.action,
							rsp.out_key);
					end
				end else begin
					exp = expected_steps.pop_front();
					if (rsp.action !== exp.action || rsp.out_key !== exp.key ||
						rsp.dest_was_newer !== exp.newer || rsp.need_side !== exp.need ||
						rsp.wrong_side !== exp.wrong) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("mismatch: expected action=%0d key=%h newer=%b need=%0d wrong=%b",
								exp.action, exp.key, exp.newer, exp.need, exp.wrong);
							$display("          actual   action=%0d key=%h newer=%b need=%0d wrong=%b",
								rsp.action, rsp.out_key, rsp.dest_was_newer, rsp.need_side,
								rsp.wrong_side);
						end
					end
				end
			end
			pending <= expected_steps.size();
			want_side <= side_now();
		end
	end

endmodule

>>> verif/tb_sorted_list_diff_merge.sv
// Testbench top: drives requests and result back-pressure, and gives the verdict.
module tb_sorted_list_diff_merge
	import sldm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ENTRIES = 780;
	localparam int HOLD_AT_ENTRY = 300;
	localparam int PAUSE_AT_ENTRY = 600;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
	localparam logic [63:0] ALL_ONES = {64{1'b1}};
	localparam logic [63:0] SEQ_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SEQ_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// Back-pressure patterns of the result receiver.
	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_SPARSE,
		STALL_DENSE
	} stall_mode_t;

	logic  clk;
	logic  arst_n;
	int    fail_count;
	int    pending;
	side_t want_side;
	int    cycle_count = 0;

	// Stimulus bookkeeping: the last keys sent on each side keep both streams ascending,
	// and the destination id is kept so that equal-key source entries can match it.
	logic [63:0] last_dest_key;
	logic [63:0] last_src_key;
	logic [63:0] last_dest_seq;
	int          burst_left;
	bit          hold_request;

	sldm_req_if req_ch ();
	sldm_rsp_if rsp_ch ();

	sorted_list_diff_merge #(.KEY_BITS(KEY_BITS_DEFAULT)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// The checker watches both channels; it also tells the stimulus which side the merge
	// wants next, so that most requests are well formed and the merge gets deep.
	sldm_merge_checker #(.KEY_BITS(KEY_BITS_DEFAULT)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.want_side  (want_side)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run, far above the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offers one request and waits for it to be taken. The sender works in bursts: when
	// a burst is used up, valid may drop for a random gap before the next one starts.
	// Called at a falling edge, and returns at the falling edge after the handshake.
	task automatic offer(input logic [2:0] cmd, input logic [63:0] key, input logic [63:0] seq);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.entry_key <= key;
		req_ch.entry_seq <= seq;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Sends a well-formed entry for the given side. Destination keys creep upwards, with
	// an occasional jump so that one side runs ahead for a while. Source keys are placed
	// around the destination head: mostly equal, otherwise just above or just below it.
	// On equal keys the id is often the same as, or one away from, the destination id.
	task automatic well_formed(input side_t side);
		logic [63:0] key;
		logic [63:0] seq;
		if (side == SIDE_DEST) begin
			key = last_dest_key + 64'((($urandom_range(0, 15) == 0) ? $urandom_range(4, 500) :
				$urandom_range(0, 3)));
			seq = {$urandom, $urandom};
			last_dest_key = key;
			last_dest_seq = seq;
			offer(CMD_DEST_ENTRY, key, seq);
		end else begin
			case ($urandom_range(0, 3))
				0, 1: key = last_dest_key;
				2: key = last_dest_key + 64'($urandom_range(1, 3));
				default: key = (last_dest_key > 3) ?
					last_dest_key - 64'($urandom_range(1, 3)) : last_dest_key;
			endcase
			if (key < last_src_key) begin
				key = last_src_key + 64'($urandom_range(0, 2));
			end
			case ($urandom_range(0, 3))
				0: seq = last_dest_seq;
				1: seq = last_dest_seq + 64'd1;
				2: seq = last_dest_seq - 64'd1;
				default: seq = {$urandom, $urandom};
			endcase
			last_src_key = key;
			offer(CMD_SRC_ENTRY, key, seq);
		end
	endtask

	// A request the merge must ignore: an undefined command, or an entry or end from the
	// side that is not wanted. Its fields are fully random.
	task automatic noise_item();
		logic [2:0] cmd;
		case ($urandom_range(0, 2))
			0: cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
			1: cmd = (want_side == SIDE_DEST) ? CMD_SRC_ENTRY : CMD_DEST_ENTRY;
			default: cmd = (want_side == SIDE_DEST) ? CMD_SRC_END : CMD_DEST_END;
		endcase
		offer(cmd, {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	// Result receiver: random stall patterns of random length, with stretches of no stall
	// at all. Once the stimulus asks, it holds ready low for a long stretch, so that the
	// block fills up and has to stall its request input.
	initial begin
		int          hold_left;
		int          mode_left;
		stall_mode_t mode;
		bit          hold_done;
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		mode_left = 0;
		mode = STALL_NONE;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					STALL_NONE: rsp_ch.ready <= 1'b1;
					STALL_COIN: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
					STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		int    ending;
		side_t closing;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_DEST_ENTRY;
		req_ch.entry_key = '0;
		req_ch.entry_seq = '0;
		arst_n = 1'b0;
		burst_left = 0;
		hold_request = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Before any entry the destination is wanted, so source requests
		// and undefined commands are ignored and flagged as coming from the wrong side.
		offer(CMD_SRC_ENTRY, ALL_ONES, SEQ_MIN);
		offer(CMD_SRC_END, '0, SEQ_MAX);
		offer(CMD_UNDEF_LO, ALL_ONES, ALL_ONES);
		offer(CMD_UNDEF_LO + 3'd1, '0, '0);
		offer(CMD_UNDEF_HI, ALL_ONES, SEQ_MIN);
		// A destination head is held, so a second destination entry or end is ignored.
		offer(CMD_DEST_ENTRY, '0, '0);
		offer(CMD_DEST_ENTRY, 64'd1, '0);
		offer(CMD_DEST_END, '0, '0);
		// Equal keys and equal ids: nothing to do, both heads are consumed.
		offer(CMD_SRC_ENTRY, '0, '0);
		// Equal keys with different ids; the ids are compared as signed values, so -1 is
		// older than 1 and the most negative id is older than the most positive one.
		offer(CMD_DEST_ENTRY, 64'd5, ALL_ONES);
		offer(CMD_SRC_ENTRY, 64'd5, 64'd1);
		offer(CMD_DEST_ENTRY, 64'd6, 64'd1);
		offer(CMD_SRC_ENTRY, 64'd6, ALL_ONES);
		offer(CMD_DEST_ENTRY, 64'd7, SEQ_MAX);
		offer(CMD_SRC_ENTRY, 64'd7, SEQ_MIN);
		// A smaller source key updates it; then a larger one deletes the destination key.
		offer(CMD_DEST_ENTRY, 64'd10, 64'd3);
		offer(CMD_SRC_ENTRY, 64'd8, 64'd4);
		offer(CMD_SRC_ENTRY, 64'd12, 64'd55);
		offer(CMD_DEST_ENTRY, 64'd12, 64'd55);

		// Random part. Keys restart from a random base, leaving room below all ones so
		// that the streams stay ascending to the end of the run.
		last_dest_key = {$urandom_range(0, 32'hFFFF_FFFE), $urandom};
		last_src_key = last_dest_key;
		last_dest_seq = '0;
		for (int n = 0; n < RANDOM_ENTRIES; n++) begin
			if (n == HOLD_AT_ENTRY) begin
				hold_request = 1'b1;
			end
			if (n == PAUSE_AT_ENTRY) begin
				// Let the block run completely dry before carrying on.
				req_ch.valid <= 1'b0;
				burst_left = 0;
				do @(negedge clk); while (pending != 0);
			end
			while ($urandom_range(0, 7) == 0) begin
				noise_item();
			end
			well_formed(want_side);
		end

		// Closing part: either one side ends and the other drains to an entry with the
		// largest key before it ends too, or the merge is aborted after a pair of
		// largest-key entries.
		ending = $urandom_range(0, 2);
		if (ending == 2) begin
			while (want_side != SIDE_DEST) begin
				well_formed(want_side);
			end
			last_dest_seq = {$urandom, $urandom};
			offer(CMD_DEST_ENTRY, ALL_ONES, last_dest_seq);
			offer(CMD_SRC_ENTRY, ALL_ONES,
				($urandom_range(0, 1) == 1) ? last_dest_seq : {$urandom, $urandom});
			offer(CMD_ABORT, {$urandom, $urandom}, {$urandom, $urandom});
		end else begin
			closing = (ending == 0) ? SIDE_DEST : SIDE_SRC;
			while (want_side != closing) begin
				well_formed(want_side);
			end
			offer((ending == 0) ? CMD_DEST_END : CMD_SRC_END, '0, '0);
			// Each entry of the remaining side now drains at once.
			repeat ($urandom_range(3, 10)) begin
				well_formed(want_side);
			end
			offer((ending == 0) ? CMD_SRC_ENTRY : CMD_DEST_ENTRY, ALL_ONES, {$urandom, $urandom});
			offer((ending == 0) ? CMD_SRC_END : CMD_DEST_END, '0, '0);
		end

		// Once stopped, an abort is ignored without a flag; everything else is flagged.
		offer(CMD_ABORT, '0, '0);
		offer(CMD_DEST_ENTRY, {$urandom, $urandom}, {$urandom, $urandom});
		offer(CMD_SRC_END, '0, '0);
		offer(CMD_UNDEF_HI, '0, '0);

		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
